// ===== hdl/drm_pkg.sv =====
// Package for the dirty rectangle merge table.
// Holds the table depth, field widths, action and status codes and the item
// and token structs shared by the cell row and the top level.
package drm_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int COORD_W     = 16;
   localparam int SLOT_W      = 5;
   localparam int COUNT_W     = 6;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 3;

   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_MERGED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_APPENDED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_READ_RANGE = 3'd5;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [COORD_W-1:0]  rect_x;
      logic [COORD_W-1:0]  rect_y;
      logic [COORD_W-1:0]  rect_w;
      logic [COORD_W-1:0]  rect_h;
      logic [SLOT_W-1:0]   entry_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [COORD_W-1:0]  out_x;
      logic [COORD_W-1:0]  out_y;
      logic [COORD_W-1:0]  out_w;
      logic [COORD_W-1:0]  out_h;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   // Token that walks the cell row: the request, the table count it saw,
   // and the result once some cell has claimed it.
   typedef struct packed {
      logic               valid;
      logic               is_read;
      logic               done;
      req_type            req;
      logic [COUNT_W-1:0] count;
      rsp_type            res;
   } token_type;

endpackage

// ===== hdl/dirty_rect_merge_table_core.sv =====
// Top level of the dirty rectangle merge table: handshakes, table count,
// limit register and the row of drm_cell entries. Depends on drm_pkg.
//
//   channel   direction  ports                          moves
//   req       in         req_valid req_ready req_data   one request item
//   rsp       out        rsp_valid rsp_ready rsp_data   one result item
//   csr       in         csr_valid csr_ready csr_data   max_entries write
//
// An add that is not dropped, and a read of a valid entry, walk the row of
// TABLE_DEPTH cells one cell per cycle, then pass the hold register to the
// output register. Clear, dropped add and out of range read answer without
// entering the row. One item is in flight at a time. Reset empties the table
// count and sets max_entries to 32; stored entries need no clearing. A stalled
// result holds in the output register and the block waits for it.
module dirty_rect_merge_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  drm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output drm_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [drm_pkg::COUNT_W-1:0]  csr_data
);
   import drm_pkg::*;

   typedef enum logic [1:0] {IDLE, BUSY, HOLD} state_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] count_ff, max_entries_ff, limit;
   logic               rsp_valid_ff, rsp_valid_in, rsp_free, accept;
   logic               is_add, is_clear, is_read, launch;
   rsp_type            rsp_ff, hold_ff, quick_rsp;
   token_type          head_ff;
   token_type          chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH:0] tok_valid;

   assign limit     = (max_entries_ff > DEPTH_COUNT) ? DEPTH_COUNT : max_entries_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign chain[0] = head_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      drm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_W'(g)),
         .prev_tok   (chain[g]),
         .next_tok   (chain[g+1])
      );
   end

   for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_valid
      assign tok_valid[g] = chain[g].valid;
   end

   // Items that need the cell row launch a token; the rest answer at once.
   always_comb begin
      is_add   = (req_data.action == ACT_ADD);
      is_clear = (req_data.action == ACT_CLEAR);
      is_read  = (req_data.action == ACT_READ);
      launch   = (is_add && (count_ff < limit)) ||
                 (is_read && ({1'b0, req_data.entry_index} < count_ff));

      quick_rsp             = '0;
      quick_rsp.entry_count = count_ff;
      priority if (is_add) begin
         quick_rsp.status = ST_DROPPED;
      end else if (is_clear) begin
         quick_rsp.status      = ST_CLEARED;
         quick_rsp.entry_count = '0;
      end else begin
         quick_rsp.status = ST_READ_RANGE;
         quick_rsp.slot   = req_data.entry_index;
      end

      rsp_valid_in = (accept && !launch && (is_add || is_clear || is_read)) ||
                     ((state_ff == HOLD) && rsp_free) ||
                     (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         count_ff       <= '0;
         max_entries_ff <= DEPTH_COUNT;
         rsp_valid_ff   <= 1'b0;
         head_ff.valid  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_entries_ff <= csr_data;
         end
         rsp_valid_ff  <= rsp_valid_in;
         head_ff.valid <= accept && launch;

         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  head_ff.is_read <= is_read;
                  head_ff.done    <= 1'b0;
                  head_ff.req     <= req_data;
                  head_ff.count   <= count_ff;
                  head_ff.res     <= '0;
                  rsp_ff          <= quick_rsp;
                  if (is_clear) begin
                     count_ff <= '0;
                  end
                  if (launch) begin
                     state_ff <= BUSY;
                  end
               end
            end
            BUSY: begin
               if (chain[TABLE_DEPTH].valid) begin
                  hold_ff  <= chain[TABLE_DEPTH].res;
                  state_ff <= HOLD;
               end
            end
            HOLD: begin
               if (rsp_free) begin
                  rsp_ff       <= hold_ff;
                  count_ff     <= hold_ff.entry_count;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // At most one token is ever in the cell row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one token in the cell row");

   // A token leaving the row has been claimed by some cell.
   a_tail_done: assert property (@(posedge clock) disable iff (reset)
      chain[TABLE_DEPTH].valid |-> chain[TABLE_DEPTH].done)
      else $error("token left the cell row unclaimed");

   // Tokens only travel while the block is busy, and then no item is taken.
   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      chain[TABLE_DEPTH].valid |-> (state_ff == BUSY) && !req_ready)
      else $error("token in the row outside the busy state");

   // The table count never exceeds the depth.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("table count beyond depth");

endmodule

// ===== hdl/drm_cell.sv =====
// One cell of the rectangle table: stores a single entry and checks the
// passing token against it. Depends on drm_pkg.
module drm_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [drm_pkg::SLOT_W-1:0] cell_index,
   input  drm_pkg::token_type prev_tok,
   output drm_pkg::token_type next_tok
);
   import drm_pkg::*;

   logic [COORD_W-1:0] ent_x_ff, ent_y_ff, ent_w_ff, ent_h_ff;
   logic [COORD_W-1:0] ent_x_in, ent_y_in, ent_w_in, ent_h_in;
   logic               ent_we;
   token_type          tok_ff, tok_in;

   logic               live, in_range, at_tail, apart;
   logic [COORD_W:0]   cr, cb, rr, rb, ex, ey, dw, dh;
   logic [COORD_W-1:0] nx, ny;

   always_comb begin
      live     = prev_tok.valid && !prev_tok.done;
      in_range = {1'b0, cell_index} < prev_tok.count;
      at_tail  = {1'b0, cell_index} == prev_tok.count;

      // Edges are inclusive and formed one bit wider so they never wrap.
      cr = {1'b0, ent_x_ff} + {1'b0, ent_w_ff};
      cb = {1'b0, ent_y_ff} + {1'b0, ent_h_ff};
      rr = {1'b0, prev_tok.req.rect_x} + {1'b0, prev_tok.req.rect_w};
      rb = {1'b0, prev_tok.req.rect_y} + {1'b0, prev_tok.req.rect_h};
      apart = (cr < {1'b0, prev_tok.req.rect_x}) || ({1'b0, ent_x_ff} > rr) ||
              (cb < {1'b0, prev_tok.req.rect_y}) || ({1'b0, ent_y_ff} > rb);

      nx = (ent_x_ff < prev_tok.req.rect_x) ? ent_x_ff : prev_tok.req.rect_x;
      ny = (ent_y_ff < prev_tok.req.rect_y) ? ent_y_ff : prev_tok.req.rect_y;
      ex = (cr > rr) ? cr : rr;
      ey = (cb > rb) ? cb : rb;
      dw = ex - {1'b0, nx};
      dh = ey - {1'b0, ny};

      tok_in   = prev_tok;
      ent_we   = 1'b0;
      ent_x_in = prev_tok.req.rect_x;
      ent_y_in = prev_tok.req.rect_y;
      ent_w_in = prev_tok.req.rect_w;
      ent_h_in = prev_tok.req.rect_h;

      if (live && !prev_tok.is_read) begin
         if (in_range && !apart) begin
            ent_we   = 1'b1;
            ent_x_in = nx;
            ent_y_in = ny;
            ent_w_in = dw[COORD_W] ? {COORD_W{1'b1}} : dw[COORD_W-1:0];
            ent_h_in = dh[COORD_W] ? {COORD_W{1'b1}} : dh[COORD_W-1:0];
            tok_in.done            = 1'b1;
            tok_in.res.status      = ST_MERGED;
            tok_in.res.entry_count = prev_tok.count;
         end else if (at_tail) begin
            ent_we = 1'b1;
            tok_in.done            = 1'b1;
            tok_in.res.status      = ST_APPENDED;
            tok_in.res.entry_count = prev_tok.count + COUNT_W'(1);
         end
         tok_in.res.slot  = cell_index;
         tok_in.res.out_x = ent_x_in;
         tok_in.res.out_y = ent_y_in;
         tok_in.res.out_w = ent_w_in;
         tok_in.res.out_h = ent_h_in;
      end else if (live && prev_tok.req.entry_index == cell_index) begin
         tok_in.done            = 1'b1;
         tok_in.res.status      = ST_READ_OK;
         tok_in.res.slot        = cell_index;
         tok_in.res.out_x       = ent_x_ff;
         tok_in.res.out_y       = ent_y_ff;
         tok_in.res.out_w       = ent_w_ff;
         tok_in.res.out_h       = ent_h_ff;
         tok_in.res.entry_count = prev_tok.count;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_x_ff <= ent_x_in;
         ent_y_ff <= ent_y_in;
         ent_w_ff <= ent_w_in;
         ent_h_ff <= ent_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign next_tok = tok_ff;

endmodule
